// ===== design/bflr_pkg.sv =====
// Package for the byte FIFO block: command codes, status codes, widths,
// reset values, the controller state type and the controller/datapath structs.
// No dependencies.
package bflr_pkg;

    // Defaults for the top-level parameters.
    localparam int STORE_DEPTH_DEF = 1024;
    localparam int MAX_BURST_DEF   = 64;

    // Fixed field widths of the command and result ports.
    localparam int KIND_W   = 3;
    localparam int CNT_W    = 11;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;

    // Command kinds.
    localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DISCARD = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RING_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2 = 2'd1;

    // Configuration reset values.
    localparam logic              RING_MODE_RST = 1'b1;
    localparam logic [SIZE_W-1:0] SIZE_LOG2_RST = 4'd10;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RUN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic exec;
        logic run_step;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic run_req;
        logic run_last;
    } t_dp_sts;

endpackage

// ===== design/bflr_ctrl.sv =====
// Controller state machine of the byte FIFO: sequences item load, execution
// and the byte-per-cycle delivery run. Depends on bflr_pkg.
module bflr_ctrl
    import bflr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_dp_sts i_sts,
    output logic    busy,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: each item is executed, then, when a run is requested, one byte is delivered per cycle.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = i_sts.run_req ? S_RUN : S_IDLE;
            end
            S_RUN: begin
                if (i_sts.run_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs decoded from the current state.
    always_comb begin
        o_cmd.load_item = 1'b0;
        o_cmd.exec      = 1'b0;
        o_cmd.run_step  = 1'b0;
        busy            = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy            = 1'b0;
                o_cmd.load_item = start;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_RUN: begin
                o_cmd.run_step = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== design/bflr_dp.sv =====
// Datapath of the byte FIFO: configuration registers, indices, burst state,
// byte store and result registers. Depends on bflr_pkg.
module bflr_dp
    import bflr_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MAX_BURST   = MAX_BURST_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic                 i_first,
    input  logic                 i_final_byte,
    input  logic [CNT_W-1:0]     i_count,
    input  logic [BYTE_W-1:0]    i_data_in,
    input  logic                 i_need_all,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic                 o_res_valid,
    output logic [STATUS_W-1:0]  o_status,
    output logic [BYTE_W-1:0]    o_data_out,
    output logic                 o_last_of_run,
    output logic [CNT_W-1:0]     o_granted,
    output logic [CNT_W-1:0]     o_occupancy,
    output logic                 o_is_empty
);

    // Largest usable capacity exponent: capacity must fit the store and the
    // size register.
    localparam int FLOOR_LOG2 = $clog2(STORE_DEPTH + 1) - 1;
    localparam int LOG2_MAX   = (FLOOR_LOG2 > 15) ? 15 : FLOOR_LOG2;
    localparam int MEM_DEPTH  = 1 << LOG2_MAX;
    localparam int ADDR_W     = LOG2_MAX;
    localparam int IDX_W      = LOG2_MAX + 2;
    localparam int BURST_W    = $clog2(MAX_BURST + 1);
    localparam int CMP_W      = (IDX_W > CNT_W) ? IDX_W : CNT_W;

    // Configuration.
    logic              r_ring_mode;
    logic [SIZE_W-1:0] r_size_log2;

    // FIFO and burst state.
    logic [IDX_W-1:0]   r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0]   r_rd_idx, n_rd_idx;
    logic               r_burst_open, n_burst_open;
    logic               r_burst_refused, n_burst_refused;
    logic [BURST_W-1:0] r_burst_len, n_burst_len;
    logic [BURST_W-1:0] r_burst_off, n_burst_off;

    // Registered item.
    logic [KIND_W-1:0] r_kind;
    logic              r_first;
    logic              r_final;
    logic [CNT_W-1:0]  r_count;
    logic [BYTE_W-1:0] r_data;
    logic              r_need_all;

    // Delivery run.
    logic [IDX_W-1:0]   r_run_addr;
    logic [BURST_W-1:0] r_run_left;

    // Byte store.
    logic [BYTE_W-1:0] r_mem [MEM_DEPTH];
    logic [BYTE_W-1:0] r_mem_q;

    // Result registers.
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_last;
    logic [CNT_W-1:0]    r_out_granted;
    logic                r_out_byte;

    // Derived capacity values.
    logic [SIZE_W-1:0] w_eff_log2;
    logic [IDX_W-1:0]  w_cap;
    logic [IDX_W-1:0]  w_cap_mask;
    logic [IDX_W-1:0]  w_wrap_mask;
    logic [IDX_W-1:0]  w_occ;
    logic [CMP_W-1:0]  w_occ_c;
    logic [CMP_W-1:0]  w_cnt_c;
    logic              w_cnt_bad;

    // Execute decisions.
    logic [STATUS_W-1:0] w_res_status;
    logic [CNT_W-1:0]    w_res_granted;
    logic                w_run_req;
    logic [BURST_W-1:0]  w_run_len;
    logic                w_mem_we;
    logic [ADDR_W-1:0]   w_mem_waddr;
    logic                w_clear;
    logic                w_do_adv;
    logic [IDX_W-1:0]    w_adv_amt;
    logic [IDX_W-1:0]    w_rd_sum;
    logic [ADDR_W-1:0]   w_rd_addr;
    logic                w_cfg_we;

    // Capacity exponent, clamped to at least one and to what the store holds.
    always_comb begin
        w_eff_log2 = r_size_log2;
        if (w_eff_log2 == '0) begin
            w_eff_log2 = SIZE_W'(1);
        end
        if (w_eff_log2 > SIZE_W'(LOG2_MAX)) begin
            w_eff_log2 = SIZE_W'(LOG2_MAX);
        end
    end

    assign w_cap       = IDX_W'(1) << w_eff_log2;
    assign w_cap_mask  = w_cap - IDX_W'(1);
    assign w_wrap_mask = (w_cap << 1) - IDX_W'(1);
    assign w_occ       = r_ring_mode ? ((r_wr_idx - r_rd_idx) & w_wrap_mask)
                                     : (r_wr_idx - r_rd_idx);
    assign w_occ_c     = CMP_W'(w_occ);
    assign w_cnt_c     = CMP_W'(r_count);
    assign w_cnt_bad   = (r_count == '0) || (r_count > CNT_W'(MAX_BURST));

    // Execute one item: decide the result and the next FIFO state.
    always_comb begin
        logic [CMP_W-1:0]   space;
        logic               open;
        logic               refused;
        logic [BURST_W-1:0] len;
        logic [BURST_W-1:0] off_next;
        logic [CMP_W-1:0]   n_run;

        space           = '0;
        open            = r_burst_open;
        refused         = r_burst_refused;
        len             = r_burst_len;
        off_next        = r_burst_off;
        n_run           = w_cnt_c;
        n_wr_idx        = r_wr_idx;
        n_burst_open    = r_burst_open;
        n_burst_refused = r_burst_refused;
        n_burst_len     = r_burst_len;
        n_burst_off     = r_burst_off;
        w_res_status    = ST_OK;
        w_res_granted   = '0;
        w_run_req       = 1'b0;
        w_run_len       = '0;
        w_mem_we        = 1'b0;
        w_mem_waddr     = ADDR_W'((r_wr_idx + IDX_W'(r_burst_off)) & w_cap_mask);
        w_clear         = 1'b0;
        w_do_adv        = 1'b0;
        w_adv_amt       = '0;

        case (r_kind)
            KIND_PUSH: begin
                if (r_first) begin
                    open = 1'b0;
                    n_burst_open = 1'b0;
                end
                if (r_first && w_cnt_bad) begin
                    w_res_status = ST_BAD;
                end else begin
                    if (r_first) begin
                        // Space is checked once, at the head of the burst.
                        space = r_ring_mode ? CMP_W'(w_cap - w_occ)
                                            : CMP_W'(w_cap - r_wr_idx);
                        open     = 1'b1;
                        refused  = w_cnt_c > space;
                        len      = r_count[BURST_W-1:0];
                        off_next = '0;
                        w_mem_waddr = ADDR_W'(r_wr_idx & w_cap_mask);
                    end
                    if (!open) begin
                        w_res_status = ST_IGNORED;
                    end else begin
                        w_mem_we     = !refused;
                        off_next     = off_next + BURST_W'(1);
                        w_res_status = refused ? ST_REFUSED : ST_OK;
                        n_burst_open    = 1'b1;
                        n_burst_refused = refused;
                        n_burst_len     = len;
                        n_burst_off     = off_next;
                        if (off_next >= len) begin
                            // Burst complete: commit the staged bytes.
                            if (!refused) begin
                                n_wr_idx = r_ring_mode
                                    ? ((r_wr_idx + IDX_W'(len)) & w_wrap_mask)
                                    : (r_wr_idx + IDX_W'(len));
                            end
                            n_burst_open = 1'b0;
                        end else if (r_final) begin
                            n_burst_open = 1'b0;
                            w_res_status = ST_BAD;
                        end
                    end
                end
            end
            KIND_POP, KIND_PEEK: begin
                n_burst_open = 1'b0;
                if (w_cnt_bad) begin
                    w_res_status = ST_BAD;
                end else if ((w_cnt_c > w_occ_c) &&
                             ((r_kind == KIND_POP) || r_need_all)) begin
                    w_res_status = ST_REFUSED;
                end else begin
                    if (w_cnt_c > w_occ_c) begin
                        n_run = w_occ_c;
                    end
                    if (n_run != '0) begin
                        w_run_req     = 1'b1;
                        w_run_len     = BURST_W'(n_run);
                        w_res_granted = CNT_W'(n_run);
                        if (r_kind == KIND_POP) begin
                            w_do_adv  = 1'b1;
                            w_adv_amt = IDX_W'(n_run);
                        end
                    end
                end
            end
            KIND_DISCARD: begin
                n_burst_open = 1'b0;
                if (w_cnt_c > w_occ_c) begin
                    w_res_status = ST_REFUSED;
                end else begin
                    w_do_adv      = 1'b1;
                    w_adv_amt     = IDX_W'(r_count);
                    w_res_granted = r_count;
                end
            end
            KIND_CLEAR: begin
                w_clear = 1'b1;
            end
            default: begin
                n_burst_open = 1'b0;
                w_res_status = ST_BAD;
            end
        endcase
    end

    // Read index advance; linear mode rewinds both indices once drained.
    assign w_rd_sum = r_rd_idx + w_adv_amt;
    always_comb begin
        n_rd_idx = r_rd_idx;
        if (w_do_adv) begin
            if (r_ring_mode) begin
                n_rd_idx = w_rd_sum & w_wrap_mask;
            end else if (w_rd_sum == r_wr_idx) begin
                n_rd_idx = '0;
            end else begin
                n_rd_idx = w_rd_sum;
            end
        end
    end

    assign w_cfg_we  = i_cfg_valid &&
                       ((i_cfg_index == CFG_RING_MODE) || (i_cfg_index == CFG_SIZE_LOG2));
    assign w_rd_addr = ADDR_W'(r_run_addr & w_cap_mask);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_mode <= RING_MODE_RST;
            r_size_log2 <= SIZE_LOG2_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_RING_MODE) begin
                r_ring_mode <= i_cfg_data[0];
            end else if (i_cfg_index == CFG_SIZE_LOG2) begin
                r_size_log2 <= i_cfg_data;
            end
        end
    end

    // FIFO indices and burst state; a register write or clear empties the FIFO.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_we || (i_cmd.exec && w_clear)) begin
            r_wr_idx        <= '0;
            r_rd_idx        <= '0;
            r_burst_open    <= 1'b0;
            r_burst_refused <= 1'b0;
            r_burst_len     <= '0;
            r_burst_off     <= '0;
        end else if (i_cmd.exec) begin
            r_wr_idx        <= (w_do_adv && !r_ring_mode && (w_rd_sum == r_wr_idx))
                               ? '0 : n_wr_idx;
            r_rd_idx        <= n_rd_idx;
            r_burst_open    <= n_burst_open;
            r_burst_refused <= n_burst_refused;
            r_burst_len     <= n_burst_len;
            r_burst_off     <= n_burst_off;
        end
    end

    // Item capture on a command transfer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind     <= i_kind;
            r_first    <= i_first;
            r_final    <= i_final_byte;
            r_count    <= i_count;
            r_data     <= i_data_in;
            r_need_all <= i_need_all;
        end
    end

    // Delivery run counters: start at the read index, one byte per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_run_addr <= r_rd_idx;
            r_run_left <= w_run_len;
        end else if (i_cmd.run_step) begin
            r_run_addr <= r_run_addr + IDX_W'(1);
            r_run_left <= r_run_left - BURST_W'(1);
        end
    end

    // Byte store: push writes during execute, runs read with registered data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_mem_we) begin
            r_mem[w_mem_waddr] <= r_data;
        end
        if (i_cmd.run_step) begin
            r_mem_q <= r_mem[w_rd_addr];
        end
    end

    // Result strobe and control fields.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_byte  <= 1'b0;
        end else begin
            r_out_valid <= (i_cmd.exec && !w_run_req) || i_cmd.run_step;
            r_out_byte  <= i_cmd.run_step;
        end
    end

    // Result payload fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_status  <= w_res_status;
            r_out_last    <= 1'b1;
            r_out_granted <= w_res_granted;
        end else if (i_cmd.run_step) begin
            r_out_status <= ST_OK;
            r_out_last   <= o_sts.run_last;
        end
    end

    assign o_sts.run_req  = w_run_req;
    assign o_sts.run_last = (r_run_left == BURST_W'(1));

    // Occupancy is stable from execute until the next item executes or a register write empties the FIFO.
    assign o_res_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_data_out    = r_out_byte ? r_mem_q : '0;
    assign o_last_of_run = r_out_last;
    assign o_granted     = r_out_granted;
    assign o_occupancy   = w_occ_c[CNT_W-1:0];
    assign o_is_empty    = (w_occ == '0);

    // A run step always yields a byte result in the next cycle.
    a_run_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.run_step |=> (r_out_valid && r_out_byte))
        else $error("run step did not produce a byte result");

    // An item without a run finishes with a single closing result.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && !w_run_req) |=> (r_out_valid && r_out_last && !r_out_byte))
        else $error("single result missing or not marked last");

    // In linear mode the read index never passes the write index.
    a_linear_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ring_mode |-> (r_rd_idx <= r_wr_idx))
        else $error("linear read index beyond write index");

    // Occupancy never exceeds capacity.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_occ <= w_cap)
        else $error("occupancy above capacity");

    // A run is never started with a zero length.
    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_run_req) |-> (w_run_len != '0))
        else $error("empty delivery run started");

endmodule

// ===== design/byte_fifo_linear_or_ring_unit.sv =====
// Top level of the byte FIFO block: controller and datapath.
// Depends on bflr_pkg, bflr_ctrl and bflr_dp.
//
// Usage: a command is transferred at a rising edge with start high and busy
// low. Kinds are push byte, pop, peek, discard and clear. Push bursts arrive
// one byte per command; each byte gives one result. Pop and peek deliver one
// result per granted byte, in order, on consecutive cycles, the last marked by
// o_last_of_run; every other command gives a single result with that mark.
// Each result is held for exactly one cycle, flagged by o_res_valid; the
// receiver must take it then, it cannot stall the block.
// Timing: a command is captured at its transfer edge and executed in the next
// cycle; a result without a run is on the ports in the cycle after that. A pop
// or peek run reads its bytes in order through the single read port of the
// byte store; each byte passes through the store's output register and the
// result registers to the ports. busy falls once the last read of a run is
// issued.
// Configuration: registers ring_mode (index 0) and size_log2 (index 1) are
// written over the cfg channel, always ready; a write to either empties the FIFO.
// Reset (synchronous, active low) selects ring mode with size_log2 at 10 and an
// empty FIFO. Store contents are not cleared and need no clearing pass.
module byte_fifo_linear_or_ring_unit
    import bflr_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MAX_BURST   = MAX_BURST_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic                 i_first,
    input  logic                 i_final_byte,
    input  logic [CNT_W-1:0]     i_count,
    input  logic [BYTE_W-1:0]    i_data_in,
    input  logic                 i_need_all,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output logic                 o_res_valid,
    output logic [STATUS_W-1:0]  o_status,
    output logic [BYTE_W-1:0]    o_data_out,
    output logic                 o_last_of_run,
    output logic [CNT_W-1:0]     o_granted,
    output logic [CNT_W-1:0]     o_occupancy,
    output logic                 o_is_empty
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Register writes are always accepted.
    assign o_cfg_ready = 1'b1;

    // Sequencer.
    bflr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (w_sts),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    // Storage and arithmetic.
    bflr_dp #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_BURST   (MAX_BURST)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (i_kind),
        .i_first       (i_first),
        .i_final_byte  (i_final_byte),
        .i_count       (i_count),
        .i_data_in     (i_data_in),
        .i_need_all    (i_need_all),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_res_valid   (o_res_valid),
        .o_status      (o_status),
        .o_data_out    (o_data_out),
        .o_last_of_run (o_last_of_run),
        .o_granted     (o_granted),
        .o_occupancy   (o_occupancy),
        .o_is_empty    (o_is_empty)
    );

endmodule

// ===== test/bflr_fifo_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the byte FIFO block: follows every command and register transfer,
// keeps its own copy of the FIFO and compares each result strobe with its prediction.
// Depends on bflr_pkg.
module bflr_fifo_checker
    import bflr_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MAX_BURST   = MAX_BURST_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic                 i_first,
    input  logic                 i_final_byte,
    input  logic [CNT_W-1:0]     i_count,
    input  logic [BYTE_W-1:0]    i_data_in,
    input  logic                 i_need_all,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_res_valid,
    input  logic [STATUS_W-1:0]  i_status,
    input  logic [BYTE_W-1:0]    i_data_out,
    input  logic                 i_last_of_run,
    input  logic [CNT_W-1:0]     i_granted,
    input  logic [CNT_W-1:0]     i_occupancy,
    input  logic                 i_is_empty,
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_fill
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   data;
        logic                last;
        logic [CNT_W-1:0]    granted;
        logic [CNT_W-1:0]    occupancy;
        logic                is_empty;
    } t_fifo_result;

    // Results the block still owes, oldest first.
    t_fifo_result fifo_results_due[$];

    // Shadow copy of the FIFO registers and contents.
    bit                ring_mode_q;
    bit [SIZE_W-1:0]   size_log2_q;
    int unsigned       wr_idx;
    int unsigned       rd_idx;
    logic [BYTE_W-1:0] byte_mem [STORE_DEPTH];
    bit                burst_open;
    bit                burst_refused;
    int unsigned       burst_len;
    int unsigned       burst_off;
    int                mismatch_cnt = 0;

    // Capacity in bytes after clamping the size register to the store depth.
    function automatic int unsigned capacity_bytes();
        int unsigned lg;
        lg = 32'(size_log2_q);
        if (lg < 1) lg = 1;
        while (lg > 1 && (1 << lg) > STORE_DEPTH) lg--;
        return 1 << lg;
    endfunction

    // Ring indices run modulo twice the capacity, so the fill is their difference.
    function automatic int unsigned fill_level();
        if (ring_mode_q) return (wr_idx - rd_idx) & (2 * capacity_bytes() - 1);
        return wr_idx - rd_idx;
    endfunction

    function automatic void empty_fifo();
        wr_idx = 0;
        rd_idx = 0;
        burst_open = 1'b0;
        burst_refused = 1'b0;
        burst_len = 0;
        burst_off = 0;
    endfunction

    // Queues one result; occupancy is taken from the state after the command.
    function automatic void owe_result(logic [STATUS_W-1:0] status, logic [BYTE_W-1:0] data,
                                       logic last, int unsigned granted);
        t_fifo_result res;
        int unsigned  occ;
        occ = fill_level();
        res.status = status;
        res.data = data;
        res.last = last;
        res.granted = CNT_W'(granted);
        res.occupancy = CNT_W'(occ);
        res.is_empty = (occ == 0);
        fifo_results_due.push_back(res);
    endfunction

    // Linear mode resets both indices once the FIFO runs dry.
    function automatic void advance_read(int unsigned n);
        if (ring_mode_q) begin
            rd_idx = (rd_idx + n) & (2 * capacity_bytes() - 1);
        end else begin
            rd_idx = rd_idx + n;
            if (rd_idx == wr_idx) begin
                rd_idx = 0;
                wr_idx = 0;
            end
        end
    endfunction

    function automatic void apply_fifo_register(logic [CFG_IDX_W-1:0] idx,
                                                logic [CFG_DAT_W-1:0] data);
        if (idx == CFG_RING_MODE) begin
            ring_mode_q = data[0];
            empty_fifo();
        end else if (idx == CFG_SIZE_LOG2) begin
            size_log2_q = data;
            empty_fifo();
        end
    endfunction

    // Push byte: bursts are staged behind the write index and committed on the last byte.
    function automatic void apply_push(logic first, logic fin, logic [CNT_W-1:0] count,
                                       logic [BYTE_W-1:0] data);
        int unsigned         cap;
        int unsigned         space;
        logic [STATUS_W-1:0] st;
        cap = capacity_bytes();
        if (first) begin
            burst_open = 1'b0;
            if (count == 0 || count > MAX_BURST) begin
                owe_result(ST_BAD, '0, 1'b1, 0);
                return;
            end
            space = ring_mode_q ? cap - fill_level() : cap - wr_idx;
            burst_open = 1'b1;
            burst_refused = count > space;
            burst_len = 32'(count);
            burst_off = 0;
        end
        if (!burst_open) begin
            owe_result(ST_IGNORED, '0, 1'b1, 0);
            return;
        end
        if (!burst_refused) byte_mem[(wr_idx + burst_off) & (cap - 1)] = data;
        burst_off++;
        st = burst_refused ? ST_REFUSED : ST_OK;
        if (burst_off >= burst_len) begin
            if (!burst_refused) begin
                if (ring_mode_q) wr_idx = (wr_idx + burst_len) & (2 * cap - 1);
                else wr_idx = wr_idx + burst_len;
            end
            burst_open = 1'b0;
        end else if (fin) begin
            // Final flag ahead of the announced length drops the burst.
            burst_open = 1'b0;
            st = ST_BAD;
        end
        owe_result(st, '0, 1'b1, 0);
    endfunction

    function automatic void apply_fifo_command(logic [KIND_W-1:0] kind, logic first,
                                               logic fin, logic [CNT_W-1:0] count,
                                               logic [BYTE_W-1:0] data, logic need_all);
        int unsigned       occ;
        int unsigned       n;
        int unsigned       k;
        int unsigned       cap;
        logic [BYTE_W-1:0] run_bytes[$];
        if (kind == KIND_PUSH) begin
            apply_push(first, fin, count, data);
            return;
        end
        // Anything but a push abandons an open burst.
        burst_open = 1'b0;
        occ = fill_level();
        cap = capacity_bytes();
        case (kind)
            KIND_POP, KIND_PEEK: begin
                if (count == 0 || count > MAX_BURST) begin
                    owe_result(ST_BAD, '0, 1'b1, 0);
                end else if (count > occ && (kind == KIND_POP || need_all)) begin
                    owe_result(ST_REFUSED, '0, 1'b1, 0);
                end else begin
                    n = (count > occ) ? occ : 32'(count);
                    if (n == 0) begin
                        owe_result(ST_OK, '0, 1'b1, 0);
                    end else begin
                        for (k = 0; k < n; k++) begin
                            run_bytes.push_back(byte_mem[(rd_idx + k) & (cap - 1)]);
                        end
                        if (kind == KIND_POP) advance_read(n);
                        for (k = 0; k < n; k++) begin
                            owe_result(ST_OK, run_bytes[k], k + 1 == n, n);
                        end
                    end
                end
            end
            KIND_DISCARD: begin
                if (count > occ) begin
                    owe_result(ST_REFUSED, '0, 1'b1, 0);
                end else begin
                    advance_read(32'(count));
                    owe_result(ST_OK, '0, 1'b1, 32'(count));
                end
            end
            KIND_CLEAR: begin
                empty_fifo();
                owe_result(ST_OK, '0, 1'b1, 0);
            end
            default: begin
                owe_result(ST_BAD, '0, 1'b1, 0);
            end
        endcase
    endfunction

    // Compare first, then register writes, then the new command of this edge.
    always @(posedge i_clk) begin
        t_fifo_result got;
        t_fifo_result want;
        if (!i_rst_n) begin
            ring_mode_q = RING_MODE_RST;
            size_log2_q = SIZE_LOG2_RST;
            empty_fifo();
            fifo_results_due.delete();
        end else begin
            if (i_res_valid) begin
                got = {i_status, i_data_out, i_last_of_run, i_granted, i_occupancy, i_is_empty};
                if (fifo_results_due.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT) begin
                        $display("%0t: result with none outstanding: status %0d data %02h last %0d",
                                 $time, got.status, got.data, got.last);
                    end
                end else begin
                    want = fifo_results_due.pop_front();
                    if (got.status !== want.status || got.data !== want.data ||
                        got.last !== want.last || got.granted !== want.granted ||
                        got.occupancy !== want.occupancy || got.is_empty !== want.is_empty) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_LIMIT) begin
                            $display("%0t: result mismatch, expected status %0d data %02h last %0d",
                                     $time, want.status, want.data, want.last,
                                     " granted %0d occupancy %0d empty %0d",
                                     want.granted, want.occupancy, want.is_empty);
                            $display("%0t:                    got status %0d data %02h last %0d",
                                     $time, got.status, got.data, got.last,
                                     " granted %0d occupancy %0d empty %0d",
                                     got.granted, got.occupancy, got.is_empty);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) apply_fifo_register(i_cfg_index, i_cfg_data);
            if (i_start && !i_busy) begin
                apply_fifo_command(i_kind, i_first, i_final_byte, i_count, i_data_in,
                                   i_need_all);
            end
        end
        o_mismatches <= mismatch_cnt;
        o_pending <= fifo_results_due.size();
        o_fill <= int'(fill_level());
    end

endmodule

// ===== test/tb_byte_fifo_linear_or_ring_unit.sv =====
`timescale 1ns / 100ps
// Top of the byte FIFO testbench: clock, reset, command and register stimulus, verdict.
// Depends on bflr_pkg, byte_fifo_linear_or_ring_unit and bflr_fifo_checker.
module tb_byte_fifo_linear_or_ring_unit;
    import bflr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 8;
    localparam int MAX_BURST      = MAX_BURST_DEF;

    // Codes the block defines no meaning for.
    localparam logic [KIND_W-1:0]    KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0]    KIND_SPARE_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI  = 2'd3;
    localparam logic [CNT_W-1:0]     CNT_ALL_ONES  = '1;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [KIND_W-1:0]    i_kind;
    logic                 i_first;
    logic                 i_final_byte;
    logic [CNT_W-1:0]     i_count;
    logic [BYTE_W-1:0]    i_data_in;
    logic                 i_need_all;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 o_res_valid;
    logic [STATUS_W-1:0]  o_status;
    logic [BYTE_W-1:0]    o_data_out;
    logic                 o_last_of_run;
    logic [CNT_W-1:0]     o_granted;
    logic [CNT_W-1:0]     o_occupancy;
    logic                 o_is_empty;

    int mismatches;
    int results_pending;
    int fifo_fill;
    int sender_idle_pct = 0;
    int quiet_cycles;

    byte_fifo_linear_or_ring_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_first       (i_first),
        .i_final_byte  (i_final_byte),
        .i_count       (i_count),
        .i_data_in     (i_data_in),
        .i_need_all    (i_need_all),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_res_valid   (o_res_valid),
        .o_status      (o_status),
        .o_data_out    (o_data_out),
        .o_last_of_run (o_last_of_run),
        .o_granted     (o_granted),
        .o_occupancy   (o_occupancy),
        .o_is_empty    (o_is_empty)
    );

    bflr_fifo_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_kind        (i_kind),
        .i_first       (i_first),
        .i_final_byte  (i_final_byte),
        .i_count       (i_count),
        .i_data_in     (i_data_in),
        .i_need_all    (i_need_all),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_res_valid   (o_res_valid),
        .i_status      (o_status),
        .i_data_out    (o_data_out),
        .i_last_of_run (o_last_of_run),
        .i_granted     (o_granted),
        .i_occupancy   (o_occupancy),
        .i_is_empty    (o_is_empty),
        .o_mismatches  (mismatches),
        .o_pending     (results_pending),
        .o_fill        (fifo_fill)
    );

    // Free-running 20 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: ends the run after too many cycles without any transfer.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_res_valid || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("byte_fifo_linear_or_ring_unit verification failed");
        $finish;
    end

    // Presents one command after a random idle gap and waits for its transfer.
    task automatic issue_command(input logic [KIND_W-1:0] kind, input logic first,
                                 input logic fin, input logic [CNT_W-1:0] count,
                                 input logic [BYTE_W-1:0] data, input logic need_all);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_kind       <= kind;
        i_first      <= first;
        i_final_byte <= fin;
        i_count      <= count;
        i_data_in    <= data;
        i_need_all   <= need_all;
        do @(posedge i_clk); while (busy);
    endtask

    // Non-push command; the fields it ignores get random values.
    task automatic issue_op(input logic [KIND_W-1:0] kind, input int count);
        issue_command(kind, 1'($urandom_range(1)), 1'($urandom_range(1)), CNT_W'(count),
                      BYTE_W'($urandom), 1'($urandom_range(1)));
    endtask

    // Sends the first 'sent' bytes of a burst announced with 'len' bytes. With 'cut'
    // set, the last byte sent carries the final flag ahead of time.
    task automatic push_burst(input int len, input int sent, input bit cut);
        int k;
        for (k = 0; k < sent; k++) begin
            issue_command(KIND_PUSH, k == 0,
                          (k == len - 1) ? 1'($urandom_range(1)) : 1'(cut && k == sent - 1),
                          (k == 0) ? CNT_W'(len) : CNT_W'($urandom), BYTE_W'($urandom),
                          1'($urandom_range(1)));
        end
    endtask

    // Byte pushed with no burst open.
    task automatic push_stray();
        issue_command(KIND_PUSH, 1'b0, 1'($urandom_range(1)), CNT_W'($urandom),
                      BYTE_W'($urandom), 1'($urandom_range(1)));
    endtask

    // Holds off new commands until every outstanding result has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Register changes only on an idle block; upper bits of the mode write are noise.
    task automatic set_config(input logic ring, input logic [CFG_DAT_W-1:0] size_log2);
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        write_register(CFG_RING_MODE, {3'($urandom), ring});
        write_register(CFG_SIZE_LOG2, size_log2);
    endtask

    // Mostly well-formed bursts and requests sized from the current fill, with some
    // malformed traffic mixed in. Halfway through, the sender drains all results.
    task automatic random_phase(input int items);
        int done;
        int pick;
        int len;
        int fill;
        int cnt;
        bit paused;
        done = 0;
        paused = 1'b0;
        while (done < items) begin
            pick = $urandom_range(99);
            fill = fifo_fill;
            if (pick < 45) begin
                // Whole burst, usually short.
                if ($urandom_range(99) < 80) len = $urandom_range(1, 6);
                else if ($urandom_range(99) < 75) len = $urandom_range(7, 20);
                else len = $urandom_range(21, MAX_BURST);
                push_burst(len, len, 1'b0);
                done += len;
            end else if (pick < 65) begin
                if (fill > 0 && fill <= MAX_BURST && $urandom_range(1)) cnt = fill;
                else cnt = $urandom_range(1, (fill + 2 < MAX_BURST) ? fill + 2 : MAX_BURST);
                issue_op(KIND_POP, cnt);
                done++;
            end else if (pick < 77) begin
                issue_op(KIND_PEEK,
                         $urandom_range(1, (fill + 3 < MAX_BURST) ? fill + 3 : MAX_BURST));
                done++;
            end else if (pick < 85) begin
                cnt = ($urandom_range(99) < 40) ? fill : $urandom_range(0, fill + 1);
                issue_op(KIND_DISCARD, cnt);
                done++;
            end else if (pick < 88) begin
                issue_op(KIND_CLEAR, $urandom_range(0, 2047));
                done++;
            end else begin
                case ($urandom_range(6))
                    0: push_stray();
                    1: begin
                        issue_op(KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
                                 $urandom_range(0, 2047));
                        done++;
                    end
                    2: begin
                        // Burst length zero or beyond the burst limit.
                        cnt = $urandom_range(1) ? 0 : $urandom_range(MAX_BURST + 1, 2047);
                        issue_command(KIND_PUSH, 1'b1, 1'($urandom_range(1)), CNT_W'(cnt),
                                      BYTE_W'($urandom), 1'($urandom_range(1)));
                        done++;
                    end
                    3: begin
                        len = $urandom_range(2, 8);
                        cnt = $urandom_range(1, len - 1);
                        push_burst(len, cnt, 1'b1);
                        push_stray();
                        done += cnt;
                    end
                    4: begin
                        // Burst abandoned by another command; the tail turns stray.
                        len = $urandom_range(3, 8);
                        cnt = $urandom_range(1, len - 1);
                        push_burst(len, cnt, 1'b0);
                        issue_op(KIND_W'($urandom_range(KIND_POP, KIND_CLEAR)),
                                 $urandom_range(0, 4));
                        push_stray();
                        done += cnt + 1;
                    end
                    5: begin
                        // A new first byte restarts an open burst.
                        len = $urandom_range(2, 8);
                        cnt = $urandom_range(1, len - 1);
                        push_burst(len, cnt, 1'b0);
                        len = $urandom_range(1, 6);
                        push_burst(len, len, 1'b0);
                        done += cnt + len;
                    end
                    default: begin
                        issue_op(KIND_W'($urandom_range(KIND_POP, KIND_PEEK)),
                                 $urandom_range(0, 2047));
                        done++;
                    end
                endcase
            end
            if (!paused && done >= items / 2) begin
                wait_for_results();
                paused = 1'b1;
            end
        end
    endtask

    // Reset, directed cases, random phases over several settings, then the verdict.
    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_kind       <= KIND_PUSH;
        i_first      <= 1'b0;
        i_final_byte <= 1'b0;
        i_count      <= '0;
        i_data_in    <= '0;
        i_need_all   <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= CFG_RING_MODE;
        i_cfg_data   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Requests on an empty FIFO in the reset setting.
        issue_command(KIND_POP, 1'b0, 1'b0, 11'd1, 8'h00, 1'b0);
        issue_command(KIND_PEEK, 1'b0, 1'b0, 11'd4, 8'h00, 1'b0);
        issue_command(KIND_PEEK, 1'b0, 1'b0, 11'd4, 8'h00, 1'b1);
        issue_command(KIND_DISCARD, 1'b0, 1'b0, 11'd0, 8'h00, 1'b0);
        issue_command(KIND_DISCARD, 1'b0, 1'b0, 11'd1, 8'h00, 1'b0);
        // Illegal burst lengths and a byte outside any burst.
        issue_command(KIND_PUSH, 1'b1, 1'b0, 11'd0, 8'h00, 1'b0);
        issue_command(KIND_PUSH, 1'b1, 1'b0, CNT_W'(MAX_BURST + 1), 8'h00, 1'b0);
        issue_command(KIND_PUSH, 1'b1, 1'b1, CNT_ALL_ONES, 8'hFF, 1'b1);
        issue_command(KIND_PUSH, 1'b0, 1'b0, 11'd0, 8'h5A, 1'b0);
        // Three byte burst with the extreme byte values.
        issue_command(KIND_PUSH, 1'b1, 1'b0, 11'd3, 8'h00, 1'b0);
        issue_command(KIND_PUSH, 1'b0, 1'b0, 11'd0, 8'hFF, 1'b0);
        issue_command(KIND_PUSH, 1'b0, 1'b1, 11'd0, 8'hA5, 1'b0);
        // Peek shortened to the fill, illegal pop and peek lengths, then a pop of two.
        issue_command(KIND_PEEK, 1'b0, 1'b0, CNT_W'(MAX_BURST), 8'h00, 1'b0);
        issue_command(KIND_POP, 1'b0, 1'b0, 11'd0, 8'h00, 1'b0);
        issue_command(KIND_POP, 1'b0, 1'b0, CNT_ALL_ONES, 8'h00, 1'b0);
        issue_command(KIND_PEEK, 1'b1, 1'b1, CNT_ALL_ONES, 8'hFF, 1'b1);
        issue_command(KIND_POP, 1'b0, 1'b0, 11'd2, 8'h00, 1'b0);
        // Final flag ahead of the announced length.
        issue_command(KIND_PUSH, 1'b1, 1'b0, 11'd4, 8'h11, 1'b0);
        issue_command(KIND_PUSH, 1'b0, 1'b1, 11'd0, 8'h22, 1'b0);
        // New first byte during an open burst.
        issue_command(KIND_PUSH, 1'b1, 1'b0, 11'd5, 8'h33, 1'b0);
        issue_command(KIND_PUSH, 1'b1, 1'b0, 11'd2, 8'h44, 1'b0);
        issue_command(KIND_PUSH, 1'b0, 1'b1, 11'd0, 8'h55, 1'b0);
        // Open burst abandoned by a discard; its next byte is stray.
        issue_command(KIND_PUSH, 1'b1, 1'b0, 11'd3, 8'h66, 1'b0);
        issue_command(KIND_DISCARD, 1'b0, 1'b0, 11'd1, 8'h00, 1'b0);
        issue_command(KIND_PUSH, 1'b0, 1'b0, 11'd0, 8'h77, 1'b0);
        issue_command(KIND_DISCARD, 1'b0, 1'b0, CNT_ALL_ONES, 8'h00, 1'b0);
        issue_command(KIND_CLEAR, 1'b0, 1'b0, 11'd0, 8'h00, 1'b0);
        issue_command(KIND_SPARE_LO, 1'b0, 1'b0, 11'd1, 8'h00, 1'b0);
        issue_command(KIND_SPARE_HI, 1'b1, 1'b1, CNT_ALL_ONES, 8'hFF, 1'b1);

        // Random phases; sizes run from the clamped maximum down to two bytes.
        set_config(1'b1, 4'd15);
        sender_idle_pct = 0;
        random_phase(25);
        set_config(1'b0, 4'd3);
        sender_idle_pct = 51;
        random_phase(25);
        wait_for_results();
        write_register(CFG_SPARE_LO, CFG_DAT_W'($urandom));
        write_register(CFG_SPARE_HI, CFG_DAT_W'($urandom));
        set_config(1'b1, 4'd0);
        sender_idle_pct = 8;
        random_phase(25);
        set_config(1'b0, 4'd10);
        sender_idle_pct = 0;
        random_phase(25);
        set_config(1'b0, 4'd1);
        sender_idle_pct = 51;
        random_phase(25);
        set_config(1'b1, 4'd2);
        sender_idle_pct = 8;
        random_phase(25);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && results_pending == 0) begin
            $display("byte_fifo_linear_or_ring_unit verification clean");
        end else begin
            $display("byte_fifo_linear_or_ring_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== byte_fifo_linear_or_ring_unit.f =====
design/bflr_pkg.sv
design/bflr_ctrl.sv
design/bflr_dp.sv
design/byte_fifo_linear_or_ring_unit.sv
test/bflr_fifo_checker.sv
test/tb_byte_fifo_linear_or_ring_unit.sv
